// ===== rtl/core/bb3_pkg.sv =====
`default_nettype none
package bb3_pkg;
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;
    localparam int unsigned FW_W = 11;
    localparam int unsigned FH_W = 13;
    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 13'd480;
    localparam logic [FH_W-1:0] FH_MAX   = 13'd4096;
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    // one 3x3 job for the averaging back end
    typedef struct packed {
        t_rgb [2:0][2:0] px;   // [row][col]
        logic [2:0]      rv;
        logic [2:0]      cv;
        logic            eor;
        logic            eof;
    } t_job;

    // channel sum plus count -> rounded mean
    // floor((2s+c)/(2c)) = floor((s + c/2) / c); divide by c through a
    // 16-bit fraction reciprocal, exact for every sum of up to nine pixels
    function automatic logic [7:0] round_mean(input logic [11:0] sum, input logic [3:0] cnt);
        logic [11:0] half;
        logic [16:0] recip;
        logic [28:0] prod;
        half = sum + {9'd0, cnt[3:1]};
        case (cnt)
            4'd2:    recip = 17'd32768;
            4'd3:    recip = 17'd21846;
            4'd4:    recip = 17'd16384;
            4'd5:    recip = 17'd13108;
            4'd6:    recip = 17'd10923;
            4'd7:    recip = 17'd9363;
            4'd8:    recip = 17'd8192;
            4'd9:    recip = 17'd7282;
            default: recip = 17'd65536;
        endcase
        prod = {17'd0, half} * {12'd0, recip};
        return prod[23:16];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bb3_if.sv =====
`default_nettype none
interface bb3_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface bb3_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       end_of_run;
    logic       end_of_frame;
    modport source (output valid, red_out, green_out, blue_out, end_of_run, end_of_frame,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, end_of_run, end_of_frame,
                    output ready);
endinterface

interface bb3_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bb3_front.sv =====
`default_nettype none
// Front end: line stores, window and position tracking. Two stages: the
// first reads the line stores, the second builds up to two jobs.
module bb3_front #(
    parameter int unsigned MAX_WIDTH = 1024,
    parameter int unsigned AW = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_restart,
    input  wire logic [10:0]          i_w,
    input  wire logic [12:0]          i_h,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic                 i_mode,
    input  wire bb3_pkg::t_rgb        i_px,
    input  wire logic                 i_space2,
    output logic                      o_push,
    output logic                      o_two,
    output bb3_pkg::t_job             o_job0,
    output bb3_pkg::t_job             o_job1
);
    logic [AW-1:0] r_col, r_fcnt;
    logic [11:0]   r_row;
    logic          r_drain;
    bb3_pkg::t_rgb r_older [MAX_WIDTH];
    bb3_pkg::t_rgb r_newer [MAX_WIDTH];

    // stage 2 holding registers
    logic          r_s_v, r_s_mode, r_s_eof;
    logic [AW:0]   r_s_c;
    logic [11:0]   r_s_r;
    bb3_pkg::t_rgb r_s_px, r_s_old, r_s_new;
    logic [AW:0]   r_s_w;
    logic          r_s_h2;
    bb3_pkg::t_rgb r_win [2:0][1:0];
    bb3_pkg::t_rgb r_fo, r_fn;

    logic [AW:0]   w_eff;
    logic [12:0]   h_eff;
    logic          fire;
    logic [AW-1:0] rd_addr;
    logic          cv_last;

    always_comb begin
        w_eff = (i_w == 11'd0) ? (AW+1)'(1)
              : ({21'd0, i_w} > 32'(MAX_WIDTH)) ? (AW+1)'(MAX_WIDTH) : (AW+1)'(i_w);
        h_eff = (i_h == 13'd0) ? 13'd1 : (i_h > bb3_pkg::FH_MAX) ? bb3_pkg::FH_MAX : i_h;
    end

    // stall only when the queue has fewer than four free entries
    assign o_ready = i_space2;
    assign fire    = i_valid && o_ready;
    assign rd_addr = (i_mode == bb3_pkg::MODE_FLUSH) ? r_fcnt
                   : ((AW+1)'(r_col) >= w_eff) ? '0 : r_col;

    // position and drain control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_col <= '0; r_row <= '0; r_fcnt <= '0; r_drain <= 1'b0; r_s_v <= 1'b0;
        end else begin
            r_s_v <= fire && (i_mode == bb3_pkg::MODE_PIXEL || r_drain);
            if (fire && i_mode == bb3_pkg::MODE_FLUSH && r_drain) begin
                if ((AW+1)'(r_fcnt) >= w_eff - 1'b1) begin
                    r_drain <= 1'b0; r_fcnt <= '0;
                end else begin
                    r_fcnt <= r_fcnt + 1'b1;
                end
            end else if (fire && i_mode == bb3_pkg::MODE_PIXEL) begin
                r_fcnt <= '0;
                if ((AW+1)'(rd_addr) >= w_eff - 1'b1) begin
                    r_col <= '0;
                    if ({1'b0, r_row} >= h_eff - 1'b1) begin
                        r_row <= '0; r_drain <= 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1; r_drain <= 1'b0;
                    end
                end else begin
                    r_col <= rd_addr + 1'b1;
                    r_drain <= 1'b0;
                end
            end
        end
    end

    // line stores: read old contents, write shifted row
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s_old <= r_older[rd_addr];
            r_s_new <= r_newer[rd_addr];
            if (i_mode == bb3_pkg::MODE_PIXEL) begin
                r_older[rd_addr] <= r_newer[rd_addr];
                r_newer[rd_addr] <= i_px;
            end
        end
    end

    // stage 1 payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_s_mode <= i_mode;
            r_s_c    <= {1'b0, rd_addr};
            r_s_r    <= r_row;
            r_s_px   <= i_px;
            r_s_w    <= w_eff;
            r_s_h2   <= (h_eff >= 13'd2);
            r_s_eof  <= ((AW+1)'(r_fcnt) == w_eff - 1'b1);
        end
    end

    // window: shift left columns for pixels
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= '0; r_win[i][1] <= '0;
            end
        end else if (r_s_v && r_s_mode == bb3_pkg::MODE_PIXEL) begin
            r_win[0][0] <= r_win[0][1]; r_win[0][1] <= r_s_old;
            r_win[1][0] <= r_win[1][1]; r_win[1][1] <= r_s_new;
            r_win[2][0] <= r_win[2][1]; r_win[2][1] <= r_s_px;
        end
    end

    // hold the column a flush read; it is the left neighbor of the next flush
    always_ff @(posedge i_clk) begin
        if (r_s_v && r_s_mode == bb3_pkg::MODE_FLUSH) begin
            r_fo <= r_s_old;
            r_fn <= r_s_new;
        end
    end

    // read column f+1 beside column f, so a flush job has its right neighbor
    logic [AW-1:0] nx_addr;
    bb3_pkg::t_rgb r_nx_old, r_nx_new;
    assign nx_addr = ((AW+1)'(rd_addr) + 1'b1 >= (AW+1)'(MAX_WIDTH)) ? rd_addr : rd_addr + 1'b1;
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_nx_old <= r_older[nx_addr];
            r_nx_new <= r_newer[nx_addr];
        end
    end

    always_comb begin
        o_job0 = '0;
        o_job1 = '0;
        o_push = 1'b0;
        o_two  = 1'b0;
        cv_last = (r_s_c == r_s_w - 1'b1);
        if (r_s_v && r_s_mode == bb3_pkg::MODE_FLUSH) begin
            o_push = 1'b1;
            o_job0.px[0][0] = r_fo; o_job0.px[0][1] = r_s_old; o_job0.px[0][2] = r_nx_old;
            o_job0.px[1][0] = r_fn; o_job0.px[1][1] = r_s_new; o_job0.px[1][2] = r_nx_new;
            o_job0.rv = {1'b0, 1'b1, r_s_h2};
            o_job0.cv = {(r_s_c + 1'b1 < r_s_w), 1'b1, (r_s_c != '0)};
            o_job0.eor = 1'b1;
            o_job0.eof = r_s_eof;
        end else if (r_s_v && r_s_r != '0) begin
            o_job0.rv = {1'b1, 1'b1, (r_s_r >= 12'd2)};
            o_job1.rv = o_job0.rv;
            o_job0.px[0] = {r_s_old, r_win[0][1], r_win[0][0]};
            o_job0.px[1] = {r_s_new, r_win[1][1], r_win[1][0]};
            o_job0.px[2] = {r_s_px,  r_win[2][1], r_win[2][0]};
            o_job0.cv = {1'b1, 1'b1, (r_s_c >= (AW+1)'(2))};
            o_job1.px[0] = {24'd0, r_s_old, r_win[0][1]};
            o_job1.px[1] = {24'd0, r_s_new, r_win[1][1]};
            o_job1.px[2] = {24'd0, r_s_px,  r_win[2][1]};
            o_job1.cv = {1'b0, 1'b1, (r_s_c != '0)};
            o_job1.eor = 1'b1;
            if (r_s_c != '0) begin
                o_push = 1'b1;
                o_two = cv_last;
                o_job0.eor = !cv_last;
            end else if (cv_last) begin
                o_push = 1'b1;
                o_job0 = o_job1;
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bb3_fifo.sv =====
`default_nettype none
// Job queue between front and back; takes up to two jobs per cycle.
module bb3_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_two,
    input  wire bb3_pkg::t_job i_job0,
    input  wire bb3_pkg::t_job i_job1,
    output logic               o_space2,
    output logic               o_valid,
    input  wire logic          i_pop,
    output bb3_pkg::t_job      o_job
);
    localparam int unsigned DEPTH = 8;
    bb3_pkg::t_job r_mem [DEPTH];
    logic [2:0] r_wp, r_rp;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    // room for two more plus the two in the front pipe
    assign o_space2 = (r_cnt <= 4'(DEPTH - 4));
    assign o_valid  = (r_cnt != '0);
    assign o_job    = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt + (i_push ? (i_two ? 4'd2 : 4'd1) : 4'd0) - ((i_pop && o_valid) ? 4'd1 : 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + (i_two ? 3'd2 : 3'd1);
            if (i_pop && o_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job0;
            if (i_two) r_mem[r_wp + 1'b1] <= i_job1;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/bb3_back.sv =====
`default_nettype none
// Back end: sum stage, then rounded mean into the output register.
module bb3_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_pop,
    input  wire bb3_pkg::t_job i_job,
    bb3_out_if.source          out
);
    logic        r_v;
    logic [11:0] r_sr, r_sg, r_sb;
    logic [3:0]  r_cnt;
    logic        r_eor, r_eof;
    logic        adv;
    logic [11:0] sr, sg, sb;
    logic [3:0]  cnt;

    assign adv   = !r_v || !out.valid || out.ready;
    assign o_pop = adv && i_valid;

    // add the valid cells
    always_comb begin
        sr = '0; sg = '0; sb = '0; cnt = '0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (i_job.rv[i] && i_job.cv[j]) begin
                    sr = sr + 12'(i_job.px[i][j].r);
                    sg = sg + 12'(i_job.px[i][j].g);
                    sb = sb + 12'(i_job.px[i][j].b);
                    cnt = cnt + 1'b1;
                end
        if (cnt == '0) cnt = 4'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0; out.valid <= 1'b0;
        end else begin
            if (adv) r_v <= o_pop;
            if (!out.valid || out.ready) out.valid <= r_v && adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sr <= sr; r_sg <= sg; r_sb <= sb; r_cnt <= cnt;
            r_eor <= i_job.eor; r_eof <= i_job.eof;
        end
        if (r_v && (!out.valid || out.ready)) begin
            out.red_out      <= bb3_pkg::round_mean(r_sr, r_cnt);
            out.green_out    <= bb3_pkg::round_mean(r_sg, r_cnt);
            out.blue_out     <= bb3_pkg::round_mean(r_sb, r_cnt);
            out.end_of_run   <= r_eor;
            out.end_of_frame <= r_eof;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/box_blur_3x3_edge_aware_unit.sv =====
`default_nettype none
// 3x3 edge-aware box blur for raster RGB pixels.
// Channels: pix (mode + RGB), res (blurred RGB, end_of_run, end_of_frame),
// cfg (index 0 frame_width, index 1 frame_height). Configure only while idle;
// a write restarts the frame.
// A pixel item at row r>=1, column c>=1 yields the result for (r-1,c-1); the
// last column yields one more. Row 0 yields nothing. After the last pixel,
// each flush item drains one result of the last row.
// Throughput: one item per cycle while the queue has room; the line-store read
// register, an eight-entry job queue, a sum register and the output register
// sit in the path between an accepted item and its result.
// Reset clears position, window and queue; the line stores are not cleared.
// When the receiver stalls, the queue fills and pix ready drops once fewer
// than four queue entries are free.
module box_blur_3x3_edge_aware_unit #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bb3_in_if.sink     pix,
    bb3_out_if.source  res,
    bb3_cfg_if.sink    cfg
);
    localparam int unsigned AW = $clog2(MAX_WIDTH);
    logic [10:0] r_w;
    logic [12:0] r_h;
    logic        cfg_wr;
    logic        push, two, space2, qv, pop;
    bb3_pkg::t_job job0, job1, qjob;
    bb3_pkg::t_rgb px_in;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready &&
                       (cfg.index == bb3_pkg::REG_FRAME_WIDTH ||
                        cfg.index == bb3_pkg::REG_FRAME_HEIGHT);
    assign px_in = '{r: pix.red_in, g: pix.green_in, b: pix.blue_in};

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= bb3_pkg::FW_RESET; r_h <= bb3_pkg::FH_RESET;
        end else if (cfg_wr) begin
            if (cfg.index == bb3_pkg::REG_FRAME_WIDTH) r_w <= cfg.data[10:0];
            else r_h <= cfg.data[12:0];
        end
    end

    bb3_front #(.MAX_WIDTH(MAX_WIDTH), .AW(AW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_restart(cfg_wr), .i_w(r_w), .i_h(r_h),
        .i_valid(pix.valid), .o_ready(pix.ready), .i_mode(pix.mode), .i_px(px_in),
        .i_space2(space2), .o_push(push), .o_two(two), .o_job0(job0), .o_job1(job1)
    );

    bb3_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_two(two),
        .i_job0(job0), .i_job1(job1), .o_space2(space2), .o_valid(qv),
        .i_pop(pop), .o_job(qjob)
    );

    bb3_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(qv), .o_pop(pop), .i_job(qjob), .out(res)
    );

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid && !res.ready |=> res.valid && $stable(res.red_out))
        else $error("result changed while stalled");
    a_two_is_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        two |-> push) else $error("double job without push");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> qv) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    localparam int unsigned LINE_DEPTH = 1024;
    localparam int unsigned SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       eor;
        logic       eof;
    } t_blur_px;

    logic i_clk;
    logic i_rst_n;

    bb3_in_if  pix ();
    bb3_out_if res ();
    bb3_cfg_if cfg ();

    box_blur_3x3_edge_aware_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .pix     (pix),
        .res     (res),
        .cfg     (cfg)
    );

    // shadow of the blur datapath
    t_blur_px    blurred_q[$];
    logic [23:0] older_line[LINE_DEPTH];
    logic [23:0] newer_line[LINE_DEPTH];
    logic [23:0] window_px[3][3];
    int unsigned next_col;
    int unsigned next_row;
    int unsigned drain_col;
    bit          draining;
    int unsigned width_reg;
    int unsigned height_reg;

    int unsigned error_count;
    int unsigned counted_items;
    bit          calm_phase;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned active_width();
        if (width_reg < 1) return 1;
        if (width_reg > LINE_DEPTH) return LINE_DEPTH;
        return width_reg;
    endfunction

    function automatic int unsigned active_height();
        if (height_reg < 1) return 1;
        if (height_reg > 4096) return 4096;
        return height_reg;
    endfunction

    // rounded mean of the in-frame cells of one neighbourhood
    function automatic t_blur_px average_window(logic [23:0] px[3][3], bit rv[3], bit cv[3],
                                                bit eof);
        int unsigned sum[3];
        int unsigned cnt;
        logic [7:0]  mean[3];
        t_blur_px    p;
        sum = '{0, 0, 0};
        cnt = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (rv[i] && cv[j]) begin
                    for (int ch = 0; ch < 3; ch++)
                        sum[ch] += px[i][j][23-8*ch -: 8];
                    cnt++;
                end
        if (cnt == 0) cnt = 1;
        for (int ch = 0; ch < 3; ch++)
            mean[ch] = 8'((2 * sum[ch] + cnt) / (2 * cnt));
        p.r = mean[0];
        p.g = mean[1];
        p.b = mean[2];
        p.eor = 1'b0;
        p.eof = eof;
        return p;
    endfunction

    function automatic logic [23:0] line_read(bit use_older, int idx);
        if (idx < 0 || idx >= LINE_DEPTH) return 24'd0;
        return use_older ? older_line[idx] : newer_line[idx];
    endfunction

    // advance the shadow by one accepted item; returns 0 when the item is ignored
    function automatic bit blur_accept(logic mode, logic [23:0] rgb);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic [23:0] px[3][3];
        bit          rv[3];
        bit          cv[3];
        t_blur_px    outs[$];
        logic [23:0] oldv;
        logic [23:0] newv;
        w = active_width();
        h = active_height();
        if (mode == bb3_pkg::MODE_FLUSH) begin
            if (!draining) return 1'b0;
            for (int j = 0; j < 3; j++) begin
                px[0][j] = line_read(1'b1, int'(drain_col) + j - 1);
                px[1][j] = line_read(1'b0, int'(drain_col) + j - 1);
                px[2][j] = 24'd0;
            end
            rv = '{h >= 2, 1'b1, 1'b0};
            cv = '{drain_col >= 1, 1'b1, drain_col + 1 < w};
            outs.push_back(average_window(px, rv, cv, drain_col == w - 1));
            if (drain_col >= w - 1) begin
                draining = 1'b0;
                drain_col = 0;
            end else begin
                drain_col++;
            end
        end else begin
            r = next_row;
            c = next_col;
            draining = 1'b0;
            drain_col = 0;
            if (c >= w) c = 0;
            oldv = line_read(1'b1, c);
            newv = line_read(1'b0, c);
            for (int i = 0; i < 3; i++) begin
                window_px[i][0] = window_px[i][1];
                window_px[i][1] = window_px[i][2];
            end
            window_px[0][2] = oldv;
            window_px[1][2] = newv;
            window_px[2][2] = rgb;
            older_line[c] = newv;
            newer_line[c] = rgb;
            rv = '{r >= 2, r >= 1, 1'b1};
            if (r >= 1 && c >= 1) begin
                cv = '{c >= 2, 1'b1, 1'b1};
                outs.push_back(average_window(window_px, rv, cv, 1'b0));
            end
            if (r >= 1 && c == w - 1) begin
                for (int i = 0; i < 3; i++) begin
                    px[i][0] = window_px[i][1];
                    px[i][1] = window_px[i][2];
                    px[i][2] = 24'd0;
                end
                cv = '{c >= 1, 1'b1, 1'b0};
                outs.push_back(average_window(px, rv, cv, 1'b0));
            end
            if (c >= w - 1) begin
                next_col = 0;
                if (r >= h - 1) begin
                    next_row = 0;
                    draining = 1'b1;
                    drain_col = 0;
                end else begin
                    next_row = (r + 1) & 12'hFFF;
                end
            end else begin
                next_col = c + 1;
                next_row = r;
            end
        end
        if (outs.size() > 0) outs[outs.size()-1].eor = 1'b1;
        foreach (outs[k]) blurred_q.push_back(outs[k]);
        return 1'b1;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_phase) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 88) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // result side stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) res.ready = 1'b0;
        else res.ready = (pick_gap() == 0);
    end

    // compare each result transfer against the oldest expected pixel
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (blurred_q.size() == 0) begin
                $display("%0t: unexpected result rgb=%h %h %h eor=%b eof=%b", $realtime,
                         res.red_out, res.green_out, res.blue_out, res.end_of_run,
                         res.end_of_frame);
                error_count++;
            end else begin
                t_blur_px exp_px;
                exp_px = blurred_q.pop_front();
                if (res.red_out !== exp_px.r) begin
                    $display("%0t: red_out expected %h actual %h", $realtime, exp_px.r,
                             res.red_out);
                    error_count++;
                end
                if (res.green_out !== exp_px.g) begin
                    $display("%0t: green_out expected %h actual %h", $realtime, exp_px.g,
                             res.green_out);
                    error_count++;
                end
                if (res.blue_out !== exp_px.b) begin
                    $display("%0t: blue_out expected %h actual %h", $realtime, exp_px.b,
                             res.blue_out);
                    error_count++;
                end
                if (res.end_of_run !== exp_px.eor) begin
                    $display("%0t: end_of_run expected %b actual %b", $realtime, exp_px.eor,
                             res.end_of_run);
                    error_count++;
                end
                if (res.end_of_frame !== exp_px.eof) begin
                    $display("%0t: end_of_frame expected %b actual %b", $realtime,
                             exp_px.eof, res.end_of_frame);
                    error_count++;
                end
            end
        end
    end

    // send one item and hold it until the transfer
    task automatic send_item(logic mode, logic [23:0] rgb);
        int unsigned gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            pix.valid = 1'b0;
        end
        @(negedge i_clk);
        pix.valid = 1'b1;
        pix.mode = mode;
        pix.red_in = rgb[23:16];
        pix.green_in = rgb[15:8];
        pix.blue_in = rgb[7:0];
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
        if (blur_accept(mode, rgb)) counted_items++;
    endtask

    // wait until every expected result is out, then let the pipe settle
    task automatic wait_drained();
        @(negedge i_clk);
        pix.valid = 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bb3_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        wait_drained();
        @(negedge i_clk);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = data;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        if (idx == bb3_pkg::REG_FRAME_WIDTH) width_reg = data[bb3_pkg::FW_W-1:0];
        else height_reg = data[bb3_pkg::FH_W-1:0];
        next_col = 0;
        next_row = 0;
        drain_col = 0;
        draining = 1'b0;
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h);
        write_reg(bb3_pkg::REG_FRAME_WIDTH, {5'($urandom), 11'(w)});
        write_reg(bb3_pkg::REG_FRAME_HEIGHT, {3'($urandom), 13'(h)});
    endtask

    function automatic logic [23:0] rand_rgb();
        return 24'($urandom);
    endfunction

    // one full frame of random pixels, then its drain
    task automatic send_frame(int unsigned w, int unsigned h, int unsigned flushes);
        for (int unsigned k = 0; k < w * h; k++) send_item(bb3_pkg::MODE_PIXEL, rand_rgb());
        for (int unsigned k = 0; k < flushes; k++) send_item(bb3_pkg::MODE_FLUSH, rand_rgb());
    endtask

    // wide two-row frame sent back to back with its full drain
    task automatic test_wide_frame();
        calm_phase = 1'b1;
        set_geometry(64, 2);
        send_frame(64, 2, 64);
        calm_phase = 1'b0;
    endtask

    // small frames with channel extremes, stray flushes and drain abandon
    task automatic test_small_corners();
        logic [23:0] corner[4];
        corner = '{24'h000000, 24'hFFFFFF, 24'hFF00FF, 24'h00FF00};
        set_geometry(3, 3);
        send_item(bb3_pkg::MODE_FLUSH, 24'hFFFFFF);
        for (int k = 0; k < 9; k++) send_item(bb3_pkg::MODE_PIXEL, corner[k % 4]);
        send_item(bb3_pkg::MODE_FLUSH, 24'h000000);
        send_item(bb3_pkg::MODE_PIXEL, 24'h808080);
        set_geometry(0, 0);
        send_item(bb3_pkg::MODE_PIXEL, 24'hFFFFFF);
        send_item(bb3_pkg::MODE_FLUSH, 24'h000000);
        send_item(bb3_pkg::MODE_FLUSH, 24'h000000);
        set_geometry(2, 8191);
        for (int k = 0; k < 4; k++) send_item(bb3_pkg::MODE_PIXEL, corner[k]);
    endtask

    // single column under the clamped tallest height, rows back to back
    task automatic test_tall_column();
        calm_phase = 1'b1;
        set_geometry(1, 8191);
        send_frame(1, 64, 1);
        calm_phase = 1'b0;
    endtask

    // random geometries and frames, with some noise and broken drains
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int unsigned roll;
        int unsigned part;
        int unsigned frames_left;
        frames_left = 0;
        w = 1;
        h = 1;
        while (counted_items < 560) begin
            if (frames_left == 0) begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
                h = $urandom_range(1, 5);
                set_geometry(w, h);
                frames_left = $urandom_range(1, 4);
                calm_phase = ($urandom_range(0, 4) == 0);
            end
            for (int unsigned k = 0; k < w * h; k++) begin
                if ($urandom_range(0, 29) == 0) send_item(bb3_pkg::MODE_FLUSH, rand_rgb());
                send_item(bb3_pkg::MODE_PIXEL, rand_rgb());
            end
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                // abandon the drain part way
                part = $urandom_range(0, w - 1);
                for (int unsigned k = 0; k < part; k++)
                    send_item(bb3_pkg::MODE_FLUSH, rand_rgb());
            end else begin
                for (int unsigned k = 0; k < w; k++) send_item(bb3_pkg::MODE_FLUSH, rand_rgb());
                if (roll > 94) send_item(bb3_pkg::MODE_FLUSH, rand_rgb());
            end
            frames_left--;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        pix.valid = 1'b0;
        pix.mode = bb3_pkg::MODE_PIXEL;
        pix.red_in = 8'd0;
        pix.green_in = 8'd0;
        pix.blue_in = 8'd0;
        cfg.valid = 1'b0;
        cfg.index = bb3_pkg::REG_FRAME_WIDTH;
        cfg.data = 16'd0;
        res.ready = 1'b0;
        error_count = 0;
        counted_items = 0;
        calm_phase = 1'b0;
        next_col = 0;
        next_row = 0;
        drain_col = 0;
        draining = 1'b0;
        width_reg = bb3_pkg::FW_RESET;
        height_reg = bb3_pkg::FH_RESET;
        foreach (older_line[k]) older_line[k] = 24'd0;
        foreach (newer_line[k]) newer_line[k] = 24'd0;
        foreach (window_px[i, j]) window_px[i][j] = 24'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_wide_frame();
        test_small_corners();
        test_tall_column();
        test_random_frames();

        wait_drained();
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
